### rtl/core/lav_pkg.sv
`timescale 1ns / 1ps

package lav_pkg;

   localparam int COMP_W  = 32;   // Q2.30 components and Q16.16 positions
   localparam int VEC_W   = 64;   // signed vector component fed to a normalizer
   localparam int MAG_W   = 63;   // magnitude of such a component
   localparam int NORM_W  = 30;   // magnitude after the block shift, msb at bit 29
   localparam int SQ_W    = 2 * NORM_W;
   localparam int RAD_W   = SQ_W + 2;   // sum of three squares
   localparam int ROOT_W  = RAD_W / 2;  // floor square root of that sum
   localparam int QUO_W   = NORM_W + 1; // quotient reaches 2^30
   localparam int ACC_W   = 66;
   localparam int RND_W   = ACC_W - 30;

   typedef logic signed [VEC_W-1:0]  wide_type;
   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [RND_W-1:0]  rnd_type;

   // floor(0.99 * 2^30)
   localparam comp_type AXIS_LIMIT = 32'sd1063004405;
   localparam acc_type  ROUND_HALF = 66'sd536870912;
   localparam rnd_type  SAT_MAX    = 36'sd2147483647;
   localparam rnd_type  SAT_MIN    = -36'sd2147483648;

endpackage

### rtl/core/lav_isqrt.sv
`timescale 1ns / 1ps

module lav_isqrt import lav_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_radicand,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int CALC_W = RAD_W + 2;

   logic [CALC_W-1:0] rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];
   logic              valid_ff[ROOT_W];

   // one root bit per stage, msb first
   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      localparam int BIT = ROOT_W - 1 - k;
      logic [CALC_W-1:0] rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;
      logic [CALC_W-1:0] trial;
      logic [CALC_W-1:0] rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev   = CALC_W'(in_radicand);
         assign root_prev  = '0;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      always_comb begin
         trial = (CALC_W'(root_prev) << (BIT + 1)) + (CALC_W'(1) << (2 * BIT));
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = root_prev | (ROOT_W'(1) << BIT);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

### rtl/core/lav_div.sv
`timescale 1ns / 1ps

module lav_div import lav_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic [2:0][NORM_W-1:0]      in_mag,
   input  logic [ROOT_W-1:0]           in_root,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [2:0][QUO_W-1:0]       out_quo,
   output logic [SIDE_W-1:0]           out_side
);

   localparam int DIV_W = NORM_W + QUO_W + 1;

   logic [DIV_W-1:0]  rem_ff  [QUO_W][3];
   logic [QUO_W-1:0]  quo_ff  [QUO_W][3];
   logic [ROOT_W-1:0] den_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];
   logic              valid_ff[QUO_W];

   // restoring division, one quotient bit per stage on all three lanes
   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      localparam int BIT = QUO_W - 1 - k;
      logic [DIV_W-1:0]  rem_prev [3];
      logic [QUO_W-1:0]  quo_prev [3];
      logic [ROOT_W-1:0] den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;
      logic [DIV_W-1:0]  trial;
      logic [DIV_W-1:0]  rem_in [3];
      logic [QUO_W-1:0]  quo_in [3];

      if (k == 0) begin : g_first
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               // round to nearest: add half the divisor
               rem_prev[i] = (DIV_W'(in_mag[i]) << NORM_W) + DIV_W'(in_root >> 1);
               quo_prev[i] = '0;
            end
         end
         assign den_prev   = in_root;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               rem_prev[i] = rem_ff[k-1][i];
               quo_prev[i] = quo_ff[k-1][i];
            end
         end
         assign den_prev   = den_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      always_comb begin
         trial = DIV_W'(den_prev) << BIT;
         for (int i = 0; i < 3; i++) begin
            if (rem_prev[i] >= trial) begin
               rem_in[i] = rem_prev[i] - trial;
               quo_in[i] = quo_prev[i] | (QUO_W'(1) << BIT);
            end else begin
               rem_in[i] = rem_prev[i];
               quo_in[i] = quo_prev[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            for (int i = 0; i < 3; i++) begin
               rem_ff[k][i] <= rem_in[i];
               quo_ff[k][i] <= quo_in[i];
            end
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];
   assign out_quo[0] = quo_ff[QUO_W-1][0];
   assign out_quo[1] = quo_ff[QUO_W-1][1];
   assign out_quo[2] = quo_ff[QUO_W-1][2];

endmodule

### rtl/core/lav_unit.sv
`timescale 1ns / 1ps

module lav_unit import lav_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  wide_type          in_vec [3],
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output comp_type          out_vec [3],
   output logic [SIDE_W-1:0] out_side
);

   localparam int ISQ_SIDE_W = 3 + 3 * NORM_W + 1 + SIDE_W;
   localparam int DIV_SIDE_W = 3 + 1 + SIDE_W;

   function automatic logic [2:0] msb8(input logic [7:0] x);
      logic [2:0] idx;
      idx = '0;
      for (int b = 0; b < 8; b++) begin
         if (x[b]) idx = 3'(b);
      end
      return idx;
   endfunction

   logic                  valid_ff [6];
   logic [SIDE_W-1:0]     side_ff  [6];
   logic [2:0]            neg_ff   [6];

   logic [MAG_W-1:0]      mag1_ff [3];
   logic [MAG_W-1:0]      mag2_ff [3];
   logic [MAG_W-1:0]      mag3_ff [3];
   logic [7:0]            nz2_ff;
   logic [2:0]            idx2_ff [8];
   logic [5:0]            pos3_ff;
   logic                  zero_ff [6];
   logic [NORM_W-1:0]     norm4_ff [3];
   logic [NORM_W-1:0]     norm5_ff [3];
   logic [NORM_W-1:0]     norm6_ff [3];
   logic [SQ_W-1:0]       sq5_ff  [3];
   logic [RAD_W-1:0]      sum6_ff;

   logic [MAG_W-1:0]      mag1_in [3];
   logic [2:0]            neg1_in;
   logic [63:0]           or_all;
   logic [7:0]            nz2_in;
   logic [2:0]            idx2_in [8];
   logic [5:0]            pos3_in;
   logic [NORM_W-1:0]     norm4_in [3];
   logic [MAG_W+NORM_W-2:0] wide_shift [3];

   // stage 1: sign and magnitude
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = in_vec[i][VEC_W-1];
         mag1_in[i] = neg1_in[i] ? MAG_W'(-in_vec[i]) : MAG_W'(in_vec[i]);
      end
   end

   // stage 2: leading one per byte of the combined magnitudes
   always_comb begin
      or_all = {1'b0, mag1_ff[0] | mag1_ff[1] | mag1_ff[2]};
      for (int c = 0; c < 8; c++) begin
         nz2_in[c]  = |or_all[c*8 +: 8];
         idx2_in[c] = msb8(or_all[c*8 +: 8]);
      end
   end

   // stage 3: pick the top nonzero byte
   always_comb begin
      pos3_in = '0;
      for (int c = 0; c < 8; c++) begin
         if (nz2_ff[c]) pos3_in = {3'(c), idx2_ff[c]};
      end
   end

   // stage 4: block shift so the largest lands in [2^29, 2^30)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wide_shift[i] = {mag3_ff[i], {(NORM_W-1){1'b0}}} >> pos3_ff;
         norm4_in[i]   = wide_shift[i][NORM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 6; s++) valid_ff[s] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < 6; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= in_side;
         neg_ff[0]  <= neg1_in;
         for (int s = 1; s < 6; s++) begin
            side_ff[s] <= side_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
         end
         zero_ff[2] <= ~|nz2_ff;
         for (int s = 3; s < 6; s++) zero_ff[s] <= zero_ff[s-1];
         zero_ff[0] <= 1'b0;
         zero_ff[1] <= 1'b0;
         nz2_ff  <= nz2_in;
         pos3_ff <= pos3_in;
         for (int c = 0; c < 8; c++) idx2_ff[c] <= idx2_in[c];
         for (int i = 0; i < 3; i++) begin
            mag1_ff[i]  <= mag1_in[i];
            mag2_ff[i]  <= mag1_ff[i];
            mag3_ff[i]  <= mag2_ff[i];
            norm4_ff[i] <= norm4_in[i];
            norm5_ff[i] <= norm4_ff[i];
            norm6_ff[i] <= norm5_ff[i];
            sq5_ff[i]   <= norm4_ff[i] * norm4_ff[i];
         end
         sum6_ff <= RAD_W'(sq5_ff[0]) + RAD_W'(sq5_ff[1]) + RAD_W'(sq5_ff[2]);
      end
   end

   logic                  isq_valid;
   logic [ROOT_W-1:0]     isq_root;
   logic [ISQ_SIDE_W-1:0] isq_side;

   lav_isqrt #(.SIDE_W(ISQ_SIDE_W)) u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .in_valid    (valid_ff[5]),
      .in_radicand (sum6_ff),
      .in_side     ({side_ff[5], zero_ff[5], norm6_ff[2], norm6_ff[1], norm6_ff[0],
                     neg_ff[5]}),
      .out_valid   (isq_valid),
      .out_root    (isq_root),
      .out_side    (isq_side)
   );

   logic [2:0][NORM_W-1:0] div_mag;
   logic                   div_valid;
   logic [2:0][QUO_W-1:0]  div_quo;
   logic [DIV_SIDE_W-1:0]  div_side;

   assign div_mag = isq_side[3 +: 3*NORM_W];

   lav_div #(.SIDE_W(DIV_SIDE_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (isq_valid),
      .in_mag    (div_mag),
      .in_root   (isq_root),
      .in_side   ({isq_side[ISQ_SIDE_W-1 -: SIDE_W + 1], isq_side[2:0]}),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   logic              out_valid_ff;
   comp_type          out_vec_ff [3];
   logic [SIDE_W-1:0] out_side_ff;
   comp_type          out_vec_in [3];

   // restore signs; an all-zero vector stays zero
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (div_side[3]) begin
            out_vec_in[i] = '0;
         end else if (div_side[i]) begin
            out_vec_in[i] = -comp_type'(div_quo[i]);
         end else begin
            out_vec_in[i] = comp_type'(div_quo[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) out_vec_ff[i] <= out_vec_in[i];
         out_side_ff <= div_side[DIV_SIDE_W-1 -: SIDE_W];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_side  = out_side_ff;
   assign out_vec[0] = out_vec_ff[0];
   assign out_vec[1] = out_vec_ff[1];
   assign out_vec[2] = out_vec_ff[2];

endmodule

### rtl/core/look_at_view_matrix.sv
`timescale 1ns / 1ps

// Look-at view matrix. Each beat on req_ carries an eye and a target point in
// signed Q16.16; each beat on rsp_ carries the right, true-up and back rows of
// the view matrix (components Q2.30, offsets Q16.16 rounded and saturated).
// The up axis is +Z, or +Y when the view direction is within 0.99 of Z.
// Equal eye and target give an all-zero result. A new beat is taken every
// cycle while rsp_ is not stalled. Three vector normalizers run in series,
// each a 31-stage square root followed by a 31-stage divider. The whole
// pipeline holds while a result waits on rsp_tready; no state is kept.
module look_at_view_matrix import lav_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // eye_x, eye_y, eye_z, target_x, target_y, target_z
   input  logic [191:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // right_x, right_y, right_z, right_offset, up_x, up_y, up_z, up_offset,
   // back_x, back_y, back_z, back_offset
   output logic [383:0] rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready
);

   logic advance;
   logic rsp_valid_ff;
   logic [383:0] rsp_data_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // input stage: direction = target - eye
   logic     in_valid_ff;
   comp_type eye_ff [3];
   wide_type dir_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            eye_ff[i] <= comp_type'(req_tdata[i*32 +: 32]);
            dir_ff[i] <= wide_type'(comp_type'(req_tdata[(i+3)*32 +: 32]))
                         - wide_type'(comp_type'(req_tdata[i*32 +: 32]));
         end
      end
   end

   // direction normalizer
   logic        f_valid;
   comp_type    f_vec [3];
   logic [95:0] f_side;

   lav_unit #(.SIDE_W(96)) u_unit_dir (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (in_valid_ff),
      .in_vec    (dir_ff),
      .in_side   ({eye_ff[2], eye_ff[1], eye_ff[0]}),
      .out_valid (f_valid),
      .out_vec   (f_vec),
      .out_side  (f_side)
   );

   // cross with the chosen up axis is a shift by 30
   logic         c1_valid_ff;
   wide_type     c1_ff [3];
   logic [191:0] c1_side_ff;
   wide_type     c1_in [3];
   logic         axis_y;

   always_comb begin
      axis_y = (f_vec[2] > AXIS_LIMIT) || (f_vec[2] < -AXIS_LIMIT);
      if (axis_y) begin
         c1_in[0] = -(wide_type'(f_vec[2]) <<< 30);
         c1_in[1] = '0;
         c1_in[2] = wide_type'(f_vec[0]) <<< 30;
      end else begin
         c1_in[0] = wide_type'(f_vec[1]) <<< 30;
         c1_in[1] = -(wide_type'(f_vec[0]) <<< 30);
         c1_in[2] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
      end else if (advance) begin
         c1_valid_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) c1_ff[i] <= c1_in[i];
         c1_side_ff <= {f_vec[2], f_vec[1], f_vec[0], f_side};
      end
   end

   // right normalizer
   logic         r_valid;
   comp_type     r_vec [3];
   logic [191:0] r_side;

   lav_unit #(.SIDE_W(192)) u_unit_right (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (c1_valid_ff),
      .in_vec    (c1_ff),
      .in_side   (c1_side_ff),
      .out_valid (r_valid),
      .out_vec   (r_vec),
      .out_side  (r_side)
   );

   comp_type rf [3];
   assign rf[0] = comp_type'(r_side[96 +: 32]);
   assign rf[1] = comp_type'(r_side[128 +: 32]);
   assign rf[2] = comp_type'(r_side[160 +: 32]);

   // r x f: products, then differences
   logic         p_valid_ff;
   wide_type     prod_ff [6];
   logic [287:0] p_side_ff;
   logic         c2_valid_ff;
   wide_type     c2_ff [3];
   logic [287:0] c2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff  <= 1'b0;
         c2_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff  <= r_valid;
         c2_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff[0] <= r_vec[1] * rf[2];
         prod_ff[1] <= r_vec[2] * rf[1];
         prod_ff[2] <= r_vec[2] * rf[0];
         prod_ff[3] <= r_vec[0] * rf[2];
         prod_ff[4] <= r_vec[0] * rf[1];
         prod_ff[5] <= r_vec[1] * rf[0];
         p_side_ff  <= {r_vec[2], r_vec[1], r_vec[0], r_side};
         c2_ff[0]   <= prod_ff[0] - prod_ff[1];
         c2_ff[1]   <= prod_ff[2] - prod_ff[3];
         c2_ff[2]   <= prod_ff[4] - prod_ff[5];
         c2_side_ff <= p_side_ff;
      end
   end

   // true-up normalizer
   logic         u_valid;
   comp_type     u_vec [3];
   logic [287:0] u_side;

   lav_unit #(.SIDE_W(288)) u_unit_up (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (c2_valid_ff),
      .in_vec    (c2_ff),
      .in_side   (c2_side_ff),
      .out_valid (u_valid),
      .out_vec   (u_vec),
      .out_side  (u_side)
   );

   comp_type ue [3];
   comp_type uf [3];
   comp_type ur [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ue[i] = comp_type'(u_side[i*32 +: 32]);
         uf[i] = comp_type'(u_side[96 + i*32 +: 32]);
         ur[i] = comp_type'(u_side[192 + i*32 +: 32]);
      end
   end

   // offsets: products, rounded sums, saturation
   logic     d1_valid_ff;
   wide_type dp_ff [3][3];
   comp_type vr_ff [3];
   comp_type vu_ff [3];
   comp_type vf_ff [3];
   logic     d2_valid_ff;
   rnd_type  q_ff [3];
   comp_type br_ff [3];
   comp_type bu_ff [3];
   comp_type bf_ff [3];
   acc_type  acc_in [3];
   rnd_type  q_in [3];
   acc_type  rnd_acc [3];
   comp_type off_in [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         acc_in[j] = acc_type'(dp_ff[j][0]) + acc_type'(dp_ff[j][1]) + acc_type'(dp_ff[j][2]);
      end
      // right and up are negated, back is not
      rnd_acc[0] = ROUND_HALF - acc_in[0];
      rnd_acc[1] = ROUND_HALF - acc_in[1];
      rnd_acc[2] = ROUND_HALF + acc_in[2];
      for (int j = 0; j < 3; j++) begin
         q_in[j] = rnd_type'(rnd_acc[j] >>> 30);
         if (q_ff[j] > SAT_MAX) begin
            off_in[j] = comp_type'(SAT_MAX);
         end else if (q_ff[j] < SAT_MIN) begin
            off_in[j] = comp_type'(SAT_MIN);
         end else begin
            off_in[j] = comp_type'(q_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff  <= 1'b0;
         d2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         d1_valid_ff  <= u_valid;
         d2_valid_ff  <= d1_valid_ff;
         rsp_valid_ff <= d2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            dp_ff[0][i] <= ur[i] * ue[i];
            dp_ff[1][i] <= u_vec[i] * ue[i];
            dp_ff[2][i] <= uf[i] * ue[i];
            vr_ff[i] <= ur[i];
            vu_ff[i] <= u_vec[i];
            vf_ff[i] <= uf[i];
            q_ff[i]  <= q_in[i];
            br_ff[i] <= vr_ff[i];
            bu_ff[i] <= vu_ff[i];
            bf_ff[i] <= -vf_ff[i];
         end
         rsp_data_ff <= {off_in[2], bf_ff[2], bf_ff[1], bf_ff[0],
                         off_in[1], bu_ff[2], bu_ff[1], bu_ff[0],
                         off_in[0], br_ff[2], br_ff[1], br_ff[0]};
      end
   end

endmodule
